@@ hdl/s2k_pkg.sv @@
// Shared types, codes and constants for the string-to-key specifier parser.
package s2k_pkg;

  // Fixed field widths
  localparam int unsigned UNITS_W   = 20;
  localparam int unsigned SALT_W    = 64;
  localparam int unsigned SLEN_W    = 4;
  localparam int unsigned HLEN_W    = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 20;

  // Salt bytes taken by salted and iterated specifiers
  localparam logic [SLEN_W-1:0] SALT_BYTES = 4'd8;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD      = 2'd1;
  localparam logic [1:0] ST_NOTAVAIL = 2'd2;

  // Specifier type codes
  localparam logic [7:0] TYPE_PLAIN    = 8'd0;
  localparam logic [7:0] TYPE_SALTED   = 8'd1;
  localparam logic [7:0] TYPE_ITERATED = 8'd3;

  // Hash IDs
  localparam logic [7:0] HID_MD5    = 8'd1;
  localparam logic [7:0] HID_SHA1   = 8'd2;
  localparam logic [7:0] HID_SHA256 = 8'd8;
  localparam logic [7:0] HID_SHA384 = 8'd9;
  localparam logic [7:0] HID_SHA512 = 8'd10;

  // Hash kinds
  localparam logic [1:0] HK_NONE = 2'd0;
  localparam logic [1:0] HK_MD5  = 2'd1;
  localparam logic [1:0] HK_SHA1 = 2'd2;
  localparam logic [1:0] HK_SHA2 = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_UNITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MD5_EN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHA2X_EN  = 2'd2;

  localparam logic [UNITS_W-1:0] MAX_UNITS_RESET = 20'd1015808;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       record_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         parse_status;
    logic [1:0]         hash_kind;
    logic [HLEN_W-1:0]  hash_len;
    logic [SALT_W-1:0]  salt_value;
    logic [SLEN_W-1:0]  salt_len;
    logic [UNITS_W-1:0] iteration_units;
  } out_item_t;

  // Configuration seen by the parser core
  typedef struct packed {
    logic [UNITS_W-1:0] max_hash_units;
    logic               md5_enable;
    logic               sha2_ext_enable;
  } cfg_t;

  // Parser phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_HASH  = 4'b0010,
    PH_SALT  = 4'b0100,
    PH_COUNT = 4'b1000
  } phase_t;

endpackage

@@ hdl/s2k_in_if.sv @@
// Input word channel: one specifier byte with its record-start flag.
interface s2k_in_if import s2k_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/s2k_out_if.sv @@
// Result word channel: one parse result per finished or failed record.
interface s2k_out_if import s2k_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/s2k_cfg_if.sv @@
// Configuration write channel: register index and write data.
interface s2k_cfg_if import s2k_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/s2k_specifier_parser.sv @@
// String-to-key specifier parser: top level with input, result and config registers.
//
// Usage: bytes of a specifier stream arrive on in_ch, one word per byte, with
// record_start set on the type byte of each record. Each record that finishes
// or fails yields exactly one word on out_ch (status, hash kind and length,
// salt, decoded iteration count); every other byte yields none. A new start
// inside a record drops that record without a result.
// cfg_ch writes the count limit and the hash enables; it is always ready and
// is to be written only while no record is in flight.
// Result path: the byte that completes a record passes the input register, and its
// result is then loaded into the result register and presented on out_ch.
// Throughput: one byte per cycle while out_ch does not hold off a waiting result;
// the whole per-byte decode sits between the input register and the result register.
// Stall: while out_ch is held off, the result register and then the input
// register fill; in_ch drops ready once both are full and nothing is lost.
// Reset: synchronous rst_n clears the parser to idle, empties both registers
// and restores the configuration defaults.
module s2k_specifier_parser import s2k_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  s2k_in_if.sink    in_ch,
  s2k_out_if.source out_ch,
  s2k_cfg_if.sink   cfg_ch
);

  cfg_t      cfg_r;
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;

  logic      out_load;
  logic      advance;
  logic      res_valid;
  out_item_t res;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_hash_units  <= MAX_UNITS_RESET;
      cfg_r.md5_enable      <= 1'b1;
      cfg_r.sha2_ext_enable <= 1'b1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_MAX_UNITS: cfg_r.max_hash_units  <= cfg_ch.data[UNITS_W-1:0];
        REG_MD5_EN:    cfg_r.md5_enable      <= cfg_ch.data[0];
        REG_SHA2X_EN:  cfg_r.sha2_ext_enable <= cfg_ch.data[0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // Advance the input word when the result register can take a new word
  assign out_load    = !out_valid_r || out_ch.ready;
  assign advance     = s1_valid_r && out_load;
  assign in_ch.ready = !s1_valid_r || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r <= in_ch.data;
    end
  end

  s2k_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (advance),
    .item       (s1_item_r),
    .cfg        (cfg_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && res_valid) begin
      out_item_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

endmodule

@@ hdl/s2k_hash_lut.sv @@
// Hash ID lookup: kind and digest length, gated by the enable registers.
module s2k_hash_lut import s2k_pkg::*; (
  input  logic [7:0]        hash_id,
  input  cfg_t              cfg,
  output logic              hit,
  output logic [1:0]        kind,
  output logic [HLEN_W-1:0] len
);

  // Match the ID against the fixed table
  always_comb begin
    hit  = 1'b0;
    kind = HK_NONE;
    len  = '0;
    case (hash_id)
      HID_MD5: begin
        hit  = cfg.md5_enable;
        kind = HK_MD5;
        len  = 7'd16;
      end
      HID_SHA1: begin
        hit  = 1'b1;
        kind = HK_SHA1;
        len  = 7'd20;
      end
      HID_SHA256: begin
        hit  = 1'b1;
        kind = HK_SHA2;
        len  = 7'd32;
      end
      HID_SHA384: begin
        hit  = cfg.sha2_ext_enable;
        kind = HK_SHA2;
        len  = 7'd48;
      end
      HID_SHA512: begin
        hit  = cfg.sha2_ext_enable;
        kind = HK_SHA2;
        len  = 7'd64;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

endmodule

@@ hdl/s2k_core.sv @@
// Parser core: phase machine, held hash fields, salt shifter and count decode.
module s2k_core import s2k_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      item_valid,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output logic      res_valid,
  output out_item_t res
);

  phase_t             phase_r, phase_nxt;
  logic [1:0]         type_r, type_nxt;
  logic [1:0]         kind_r, kind_nxt;
  logic [HLEN_W-1:0]  hlen_r, hlen_nxt;
  logic [SALT_W-1:0]  salt_r, salt_nxt;
  logic [SLEN_W-1:0]  cnt_r, cnt_nxt;

  logic               lut_hit;
  logic [1:0]         lut_kind;
  logic [HLEN_W-1:0]  lut_len;
  logic [UNITS_W-1:0] units;
  logic [7:0]         b;

  assign b = item.data_byte;

  s2k_hash_lut u_lut (
    .hash_id (b),
    .cfg     (cfg),
    .hit     (lut_hit),
    .kind    (lut_kind),
    .len     (lut_len)
  );

  // Decode the count byte: (16 + low nibble) shifted by high nibble
  assign units = {15'd0, 1'b1, b[3:0]} << b[7:4];

  // Next state and result for the current byte
  always_comb begin
    phase_nxt = phase_r;
    type_nxt  = type_r;
    kind_nxt  = kind_r;
    hlen_nxt  = hlen_r;
    salt_nxt  = salt_r;
    cnt_nxt   = cnt_r;
    res_valid = 1'b0;
    res       = '0;
    if (item_valid) begin
      if (item.record_start) begin
        // Start a new record, drop whatever was in progress
        salt_nxt = '0;
        cnt_nxt  = '0;
        kind_nxt = HK_NONE;
        hlen_nxt = '0;
        if (b != TYPE_PLAIN && b != TYPE_SALTED && b != TYPE_ITERATED) begin
          type_nxt         = 2'd0;
          phase_nxt        = PH_IDLE;
          res_valid        = 1'b1;
          res.parse_status = ST_BAD;
        end else begin
          type_nxt  = b[1:0];
          phase_nxt = PH_HASH;
        end
      end else begin
        case (phase_r)
          PH_HASH: begin
            if (!lut_hit) begin
              phase_nxt        = PH_IDLE;
              res_valid        = 1'b1;
              res.parse_status = ST_NOTAVAIL;
            end else begin
              kind_nxt = lut_kind;
              hlen_nxt = lut_len;
              if (type_r == TYPE_PLAIN[1:0]) begin
                phase_nxt        = PH_IDLE;
                res_valid        = 1'b1;
                res.parse_status = ST_OK;
                res.hash_kind    = lut_kind;
                res.hash_len     = lut_len;
              end else begin
                salt_nxt  = '0;
                cnt_nxt   = '0;
                phase_nxt = PH_SALT;
              end
            end
          end
          PH_SALT: begin
            // Shift in one salt byte, first byte ends on top
            salt_nxt = {salt_r[SALT_W-9:0], b};
            cnt_nxt  = cnt_r + 1'b1;
            if (cnt_nxt == SALT_BYTES) begin
              if (type_r == TYPE_SALTED[1:0]) begin
                phase_nxt        = PH_IDLE;
                res_valid        = 1'b1;
                res.parse_status = ST_OK;
                res.hash_kind    = kind_r;
                res.hash_len     = hlen_r;
                res.salt_value   = salt_nxt;
                res.salt_len     = SALT_BYTES;
              end else begin
                phase_nxt = PH_COUNT;
              end
            end
          end
          PH_COUNT: begin
            phase_nxt      = PH_IDLE;
            res_valid      = 1'b1;
            res.hash_kind  = kind_r;
            res.hash_len   = hlen_r;
            res.salt_value = salt_r;
            res.salt_len   = SALT_BYTES;
            if (units > cfg.max_hash_units) begin
              res.parse_status = ST_NOTAVAIL;
            end else begin
              res.parse_status    = ST_OK;
              res.iteration_units = units;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      type_r  <= '0;
      kind_r  <= '0;
      hlen_r  <= '0;
      salt_r  <= '0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      type_r  <= type_nxt;
      kind_r  <= kind_nxt;
      hlen_r  <= hlen_nxt;
      salt_r  <= salt_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the string-to-key specifier parser.
`timescale 1ns / 100ps

module tb;
  import s2k_pkg::*;

  localparam int ITEM_TARGET   = 700;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 20;
  localparam int LONG_HOLD     = 250;

  // Type byte outside the known set, used to close an open record
  localparam logic [7:0] TYPE_UNUSED = 8'd2;
  localparam logic [7:0] HID_UNKNOWN = 8'hFF;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef logic [7:0] byte_q_t[$];

  logic clk;
  logic rst_n;

  s2k_in_if  in_ch ();
  s2k_out_if out_ch ();
  s2k_cfg_if cfg_ch ();

  s2k_specifier_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Parser state and register copies tracked by the bench
  phase_t             ph;
  logic [7:0]         spec_code;
  logic [1:0]         held_kind;
  logic [HLEN_W-1:0]  held_len;
  logic [SALT_W-1:0]  salt_acc;
  logic [SLEN_W-1:0]  salt_seen;
  logic [UNITS_W-1:0] max_units;
  logic               md5_on;
  logic               sha2x_on;

  out_item_t due_results[$];

  int errors         = 0;
  int fed_bytes      = 0;
  int rx_hold_cycles = 0;
  bit tx_steady      = 1'b0;
  bit rx_steady      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [31:0] count_units(logic [7:0] c);
    return (32'd16 + c[3:0]) << c[7:4];
  endfunction

  // Advance the tracked parser by one byte; queue any result it finishes.
  // Returns 0 for a byte that the parser drops while idle.
  function automatic bit track_specifier(logic [7:0] b, logic st);
    out_item_t r;
    logic [1:0] k;
    logic [HLEN_W-1:0] l;
    bit hit;
    logic [31:0] units;
    r = '0;
    if (st) begin
      salt_acc  = '0;
      salt_seen = '0;
      held_kind = HK_NONE;
      held_len  = '0;
      if (b != TYPE_PLAIN && b != TYPE_SALTED && b != TYPE_ITERATED) begin
        spec_code = TYPE_PLAIN;
        ph = PH_IDLE;
        r.parse_status = ST_BAD;
        due_results.push_back(r);
      end else begin
        spec_code = b;
        ph = PH_HASH;
      end
      return 1'b1;
    end
    case (ph)
      PH_HASH: begin
        hit = 1'b1;
        k = HK_NONE;
        l = '0;
        case (b)
          HID_MD5: begin
            hit = md5_on;
            k = HK_MD5;
            l = 7'd16;
          end
          HID_SHA1: begin
            k = HK_SHA1;
            l = 7'd20;
          end
          HID_SHA256: begin
            k = HK_SHA2;
            l = 7'd32;
          end
          HID_SHA384: begin
            hit = sha2x_on;
            k = HK_SHA2;
            l = 7'd48;
          end
          HID_SHA512: begin
            hit = sha2x_on;
            k = HK_SHA2;
            l = 7'd64;
          end
          default: hit = 1'b0;
        endcase
        if (!hit) begin
          ph = PH_IDLE;
          r.parse_status = ST_NOTAVAIL;
          due_results.push_back(r);
        end else begin
          held_kind = k;
          held_len  = l;
          if (spec_code == TYPE_PLAIN) begin
            ph = PH_IDLE;
            r.parse_status = ST_OK;
            r.hash_kind    = k;
            r.hash_len     = l;
            due_results.push_back(r);
          end else begin
            salt_acc  = '0;
            salt_seen = '0;
            ph = PH_SALT;
          end
        end
      end
      PH_SALT: begin
        salt_acc  = {salt_acc[SALT_W-9:0], b};
        salt_seen = salt_seen + 1'b1;
        if (salt_seen >= SALT_BYTES) begin
          if (spec_code == TYPE_SALTED) begin
            ph = PH_IDLE;
            r.parse_status = ST_OK;
            r.hash_kind    = held_kind;
            r.hash_len     = held_len;
            r.salt_value   = salt_acc;
            r.salt_len     = SALT_BYTES;
            due_results.push_back(r);
          end else begin
            ph = PH_COUNT;
          end
        end
      end
      PH_COUNT: begin
        units = count_units(b);
        ph = PH_IDLE;
        r.hash_kind  = held_kind;
        r.hash_len   = held_len;
        r.salt_value = salt_acc;
        r.salt_len   = SALT_BYTES;
        if (units > max_units) begin
          r.parse_status = ST_NOTAVAIL;
        end else begin
          r.parse_status    = ST_OK;
          r.iteration_units = units[UNITS_W-1:0];
        end
        due_results.push_back(r);
      end
      default: begin
        ph = PH_IDLE;
        return 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  // Offer one byte after a random gap; hold it until the parser takes it
  task automatic put_byte(input logic [7:0] b, input logic st);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{data_byte: b, record_start: st};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (track_specifier(b, st)) fed_bytes++;
  endtask

  // First byte of the record carries the start flag
  task automatic put_record(input byte_q_t seq);
    foreach (seq[i]) put_byte(seq[i], i == 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_MAX_UNITS: max_units = val[UNITS_W-1:0];
      REG_MD5_EN:    md5_on    = val[0];
      REG_SHA2X_EN:  sha2x_on  = val[0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Close any open record, stop the input and wait for the parser to drain
  task automatic settle_parser();
    if (ph != PH_IDLE) put_record('{TYPE_UNUSED});
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [CFG_DAT_W-1:0] lim,
                               input logic [CFG_DAT_W-1:0] md5_word,
                               input logic [CFG_DAT_W-1:0] sha2x_word);
    settle_parser();
    write_reg(REG_MAX_UNITS, lim);
    write_reg(REG_MD5_EN, md5_word);
    write_reg(REG_SHA2X_EN, sha2x_word);
  endtask

  // Mostly well-formed records with random content, some noise and cut-offs
  task automatic send_random_record();
    logic [7:0] typ;
    logic [7:0] c;
    int roll;
    int stop_at;
    byte_q_t seq;
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      // stray word without a start flag
      put_byte(8'($urandom), 1'b0);
      return;
    end
    if (roll < 10) begin
      do typ = 8'($urandom);
      while (typ == TYPE_PLAIN || typ == TYPE_SALTED || typ == TYPE_ITERATED);
    end else begin
      case ($urandom_range(0, 2))
        0:       typ = TYPE_PLAIN;
        1:       typ = TYPE_SALTED;
        default: typ = TYPE_ITERATED;
      endcase
    end
    seq = {typ};
    if (typ == TYPE_PLAIN || typ == TYPE_SALTED || typ == TYPE_ITERATED) begin
      if ($urandom_range(0, 9) < 8) begin
        case ($urandom_range(0, 4))
          0:       seq.push_back(HID_MD5);
          1:       seq.push_back(HID_SHA1);
          2:       seq.push_back(HID_SHA256);
          3:       seq.push_back(HID_SHA384);
          default: seq.push_back(HID_SHA512);
        endcase
      end else begin
        seq.push_back(8'($urandom));
      end
      if (typ != TYPE_PLAIN) begin
        repeat (SALT_BYTES) begin
          case ($urandom_range(0, 9))
            0:       seq.push_back(8'h00);
            1:       seq.push_back(8'hFF);
            default: seq.push_back(8'($urandom));
          endcase
        end
      end
      if (typ == TYPE_ITERATED) begin
        if ($urandom_range(0, 1)) begin
          c = 8'($urandom);
        end else begin
          // land on the limit: largest accepted code, or the one just above
          c = 8'h00;
          for (int k = 0; k < 256; k++)
            if (count_units(8'(k)) <= max_units) c = 8'(k);
          if ($urandom_range(0, 1) && c != 8'hFF) c = c + 8'd1;
        end
        seq.push_back(c);
      end
    end
    // cut some records short; the next start abandons them
    if ($urandom_range(0, 9) == 0) begin
      stop_at = $urandom_range(1, seq.size());
      while (seq.size() > stop_at) void'(seq.pop_back());
    end
    put_record(seq);
  endtask

  task automatic run_records(input int n);
    int goal;
    goal = fed_bytes + n;
    while (fed_bytes < goal) send_random_record();
  endtask

  task automatic test_directed_cases();
    // byte while idle is dropped
    put_byte(8'hAA, 1'b0);
    put_record('{8'hFF});
    put_record('{TYPE_UNUSED});
    put_record('{TYPE_PLAIN, HID_MD5});
    put_record('{TYPE_PLAIN, HID_SHA384});
    put_record('{TYPE_PLAIN, HID_UNKNOWN});
    // new start inside a record drops it silently
    put_record('{TYPE_SALTED, HID_SHA1, 8'h01});
    put_record('{TYPE_ITERATED, HID_SHA512, 8'hFF, 8'h00, 8'hFF, 8'h00,
                 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF});
  endtask

  task automatic test_register_settings();
    // zero limit rejects every count; enables keep only bit 0
    apply_setting(20'd0, 20'd2, 20'd0);
    write_reg(REG_UNUSED, 20'hFFFFF);
    run_records(45);
    apply_setting(20'd1, 20'd1, 20'd0);
    run_records(45);
    apply_setting(20'd16, 20'd0, 20'd1);
    run_records(45);
    apply_setting(20'd1015807, 20'd1, 20'd1);
    run_records(45);
    apply_setting(MAX_UNITS_RESET, 20'd0, 20'd0);
    run_records(45);
    apply_setting(20'hFFFFF, 20'd1, 20'd1);
    run_records(45);
    repeat (2) begin
      apply_setting(20'($urandom_range(1, MAX_UNITS_RESET)),
                    20'($urandom_range(0, 1)), 20'($urandom_range(0, 1)));
      run_records(45);
    end
  endtask

  task automatic test_output_backpressure();
    apply_setting(MAX_UNITS_RESET, 20'd1, 20'd1);
    tx_steady = 1'b1;
    rx_hold_cycles = LONG_HOLD;
    repeat (12) put_record('{TYPE_PLAIN, HID_SHA1});
    run_records(30);
    tx_steady = 1'b0;
    // hold the sender until every queued result is out
    settle_parser();
  endtask

  task automatic test_random_stream();
    while (fed_bytes < ITEM_TARGET) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      run_records(60);
      if ($urandom_range(0, 2) == 0)
        apply_setting(20'($urandom_range(0, MAX_UNITS_RESET)),
                      20'($urandom_range(0, 1)), 20'($urandom_range(0, 1)));
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Result receiver: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end else if (!rx_steady) begin
        n = pick_gap();
        if (n > 0) begin
          out_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Compare each result word with the oldest expectation
  initial begin : result_check
    out_item_t got;
    out_item_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (due_results.size() == 0) begin
          $display("%0t: result word with nothing expected, actual %h", $time, got);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("parse_status", want.parse_status, got.parse_status);
          check_field("hash_kind", want.hash_kind, got.hash_kind);
          check_field("hash_len", want.hash_len, got.hash_len);
          check_field("salt_value", want.salt_value, got.salt_value);
          check_field("salt_len", want.salt_len, got.salt_len);
          check_field("iteration_units", want.iteration_units, got.iteration_units);
        end
      end
    end
  end

  // Stop the run if no word moves on any channel for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle = 0;
      else
        idle++;
    end
    $display("%0t: no progress, %0d results outstanding", $time, due_results.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : main_seq
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data  <= '0;
    ph        = PH_IDLE;
    spec_code = TYPE_PLAIN;
    held_kind = HK_NONE;
    held_len  = '0;
    salt_acc  = '0;
    salt_seen = '0;
    max_units = MAX_UNITS_RESET;
    md5_on    = 1'b1;
    sha2x_on  = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_register_settings();
    test_output_backpressure();
    test_random_stream();

    // drain, then allow for late words
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/s2k_pkg.sv
hdl/s2k_in_if.sv
hdl/s2k_out_if.sv
hdl/s2k_cfg_if.sv
hdl/s2k_hash_lut.sv
hdl/s2k_core.sv
hdl/s2k_specifier_parser.sv
bench/tb.sv
